FILE: sv/heu_pkg.sv
// ----------------------------------------------------------------------------
// Hamming encode and syndrome package
// Shared widths, codes, types and constant wiring functions for the
// even-parity Hamming encoder and syndrome checker.
// ----------------------------------------------------------------------------
package heu_pkg;

   // Field widths, fixed by the stream formats
   localparam int MSG_BITS  = 32;
   localparam int WORD_BITS = 38;
   localparam int LEN_BITS  = 6;
   localparam int PAR_BITS  = 3;
   localparam int SYN_BITS  = 6;

   // Packed stream widths, padded up to whole bytes
   localparam int REQ_FIELD_BITS = MSG_BITS + LEN_BITS + WORD_BITS + LEN_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = WORD_BITS + LEN_BITS + PAR_BITS + SYN_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_TDATA_BITS - RSP_FIELD_BITS;

   // Saturation limits for the two length fields
   localparam logic [LEN_BITS-1:0] MAX_MSG_LEN  = LEN_BITS'(32);
   localparam logic [LEN_BITS-1:0] MAX_WORD_LEN = LEN_BITS'(WORD_BITS);

   // Action codes carried on tuser
   localparam logic ACT_ENCODE = 1'b0;
   localparam logic ACT_CHECK  = 1'b1;

   typedef logic [MSG_BITS-1:0]  msg_type;
   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [LEN_BITS-1:0]  len_type;
   typedef logic [PAR_BITS-1:0]  pc_type;
   typedef logic [SYN_BITS-1:0]  syn_type;

   // Least r of at least 1 with 2^r >= m + r + 1.
   function automatic pc_type parity_count(len_type m);
      pc_type pc;
      pc = pc_type'(SYN_BITS);
      for (int r = SYN_BITS; r >= 1; r--) begin
         if ((1 << r) >= (int'(m) + r + 1)) begin
            pc = pc_type'(r);
         end
      end
      return pc;
   endfunction

   // Positions whose index (from 1) has bit i set.
   function automatic word_type cover_mask(int i);
      word_type mask;
      mask = '0;
      for (int k = 1; k <= WORD_BITS; k++) begin
         mask[k-1] = ((k >> i) & 1) == 1;
      end
      return mask;
   endfunction

   // Message bits in order into the positions that are not powers of two.
   function automatic word_type spread_data(msg_type d);
      word_type w;
      int       dpos;
      w    = '0;
      dpos = 0;
      for (int k = 1; k <= WORD_BITS; k++) begin
         if ((k & (k - 1)) != 0) begin
            if (dpos < MSG_BITS) begin
               w[k-1] = d[dpos];
            end
            dpos++;
         end
      end
      return w;
   endfunction

endpackage

FILE: sv/heu_encoder.sv
// ----------------------------------------------------------------------------
// Hamming encoder
// Places the valid message bits into the data positions and fills in the
// even-parity bits at the power-of-two positions.
// ----------------------------------------------------------------------------
module heu_encoder (
   input  heu_pkg::msg_type  msg,
   input  heu_pkg::len_type  msg_len,
   input  heu_pkg::pc_type   pc,
   output heu_pkg::word_type codeword,
   output heu_pkg::len_type  cw_len
);
   import heu_pkg::*;

   msg_type  keep;
   word_type data_w;

   always_comb begin
      for (int j = 0; j < MSG_BITS; j++) begin
         keep[j] = LEN_BITS'(j) < msg_len;
      end
   end

   assign data_w = spread_data(msg & keep);

   // Parity positions hold zero in data_w, and parity bits at or above the
   // parity count come out zero as no data position reaches them.
   always_comb begin
      codeword = data_w;
      for (int i = 0; i < SYN_BITS; i++) begin
         codeword[(1 << i) - 1] = ^(data_w & cover_mask(i));
      end
   end

   assign cw_len = msg_len + len_type'(pc);

endmodule

FILE: sv/heu_syndrome.sv
// ----------------------------------------------------------------------------
// Hamming syndrome checker
// Computes the even-parity syndrome over the valid received positions.
// ----------------------------------------------------------------------------
module heu_syndrome (
   input  heu_pkg::word_type rx_word,
   input  heu_pkg::len_type  rx_len,
   input  heu_pkg::pc_type   pc,
   output heu_pkg::syn_type  syndrome
);
   import heu_pkg::*;

   word_type valid_pos;

   always_comb begin
      for (int k = 0; k < WORD_BITS; k++) begin
         valid_pos[k] = LEN_BITS'(k) < rx_len;
      end
   end

   always_comb begin
      for (int i = 0; i < SYN_BITS; i++) begin
         syndrome[i] = (PAR_BITS'(i) < pc) & (^(rx_word & valid_pos & cover_mask(i)));
      end
   end

endmodule

FILE: sv/hamming_encode_and_syndrome_unit.sv
// ----------------------------------------------------------------------------
// Hamming encode and syndrome unit
// Even-parity Hamming encoder and syndrome checker, one transaction per cycle while the receiver keeps up.
// ----------------------------------------------------------------------------
// Usage:
//   Each request transaction carries an action on req_tuser (encode or check)
//   and both the message and the received word on req_tdata. Encode returns
//   the codeword, its length and the parity count; check returns the parity
//   count and the syndrome, with the encode-only fields zero.
//   The datapath is an input register, one pass of short parity logic and a
//   result register. A request accepted into the input register passes the
//   parity logic into the result register, which drives rsp_tvalid.
//   Throughput is one transaction per cycle, limited only by the handshake.
//   When the receiver stalls, the result register holds its response and the
//   input register still takes one more request; once both are full,
//   req_tready falls until rsp_tready frees the output stage.
//   Reset is synchronous and active high; it empties both stages, so no
//   response is presented and req_tready is high in the cycle after reset.
//   The unit holds no state between transactions.
// ----------------------------------------------------------------------------
module hamming_encode_and_syndrome_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [31:0] message_bits, [37:32] message_length, [75:38] received_word,
   // [81:76] received_length, upper bits zero
   input  logic [heu_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // [0] action
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [37:0] codeword, [43:38] codeword_length, [46:44] parity_count,
   // [52:47] syndrome, upper bits zero
   output logic [heu_pkg::RSP_TDATA_BITS-1:0] rsp_tdata
);
   import heu_pkg::*;

   // Input stage
   logic     in_valid_ff, in_valid_in;
   logic     in_action_ff;
   msg_type  in_msg_ff;
   len_type  in_msg_len_ff;
   word_type in_rx_ff;
   len_type  in_rx_len_ff;

   // Output stage
   logic                      out_valid_ff, out_valid_in;
   logic [RSP_TDATA_BITS-1:0] out_data_ff, out_data_in;

   logic     req_take;
   logic     out_load;
   len_type  msg_len_sat;
   len_type  rx_len_sat;
   pc_type   pc;
   word_type enc_word;
   len_type  enc_len;
   syn_type  syn;
   word_type res_word;
   len_type  res_len;
   syn_type  res_syn;

   // The output stage loads whenever the input stage holds a request and the output
   // is empty or its response is being taken; the input stage then frees up in the same cycle.
   assign out_load   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff  <= req_tuser;
         in_msg_ff     <= req_tdata[MSG_BITS-1:0];
         in_msg_len_ff <= req_tdata[MSG_BITS +: LEN_BITS];
         in_rx_ff      <= req_tdata[MSG_BITS+LEN_BITS +: WORD_BITS];
         in_rx_len_ff  <= req_tdata[MSG_BITS+LEN_BITS+WORD_BITS +: LEN_BITS];
      end
   end

   // Over-long lengths are clamped before anything else sees them.
   assign msg_len_sat = (in_msg_len_ff > MAX_MSG_LEN) ? MAX_MSG_LEN : in_msg_len_ff;
   assign rx_len_sat  = (in_rx_len_ff > MAX_WORD_LEN) ? MAX_WORD_LEN : in_rx_len_ff;

   // The parity count always follows the message length, in both actions.
   assign pc = parity_count(msg_len_sat);

   heu_encoder u_encoder (
      .msg      (in_msg_ff),
      .msg_len  (msg_len_sat),
      .pc       (pc),
      .codeword (enc_word),
      .cw_len   (enc_len)
   );

   heu_syndrome u_syndrome (
      .rx_word  (in_rx_ff),
      .rx_len   (rx_len_sat),
      .pc       (pc),
      .syndrome (syn)
   );

   // Fields that belong to the other action are reported as zero.
   always_comb begin
      unique case (in_action_ff)
         ACT_ENCODE: begin
            res_word = enc_word;
            res_len  = enc_len;
            res_syn  = '0;
         end
         ACT_CHECK: begin
            res_word = '0;
            res_len  = '0;
            res_syn  = syn;
         end
         default: begin
            res_word = '0;
            res_len  = '0;
            res_syn  = '0;
         end
      endcase
   end

   assign out_data_in = {{RSP_PAD_BITS{1'b0}}, res_syn, pc, res_len, res_word};

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

FILE: sim/hamming_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hamming result checker
// Watches both streams of the encode and syndrome unit, works out the
// response due to each accepted request and compares every response with it.
// ----------------------------------------------------------------------------
module hamming_result_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [heu_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input  logic                               req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [heu_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   output int                                 error_count,
   output int                                 pending_count
);
   import heu_pkg::*;

   typedef struct packed {
      syn_type  syndrome;
      pc_type   parity_count;
      len_type  codeword_length;
      word_type codeword;
   } coded_result_type;

   coded_result_type awaited_results[$];

   // Codeword or syndrome that one request calls for.
   function automatic coded_result_type hamming_outcome(logic act, msg_type msg,
                                                        len_type msg_len,
                                                        word_type rx_word,
                                                        len_type rx_len);
      coded_result_type res;
      int               m;
      int               r;
      int               span;
      int               slot;
      logic             acc;
      res  = '0;
      m    = (msg_len > MAX_MSG_LEN) ? int'(MAX_MSG_LEN) : int'(msg_len);
      r    = 1;
      while ((1 << r) < m + r + 1) begin
         r++;
      end
      res.parity_count = pc_type'(r);
      if (act == ACT_ENCODE) begin
         span = m + r;
         res.codeword_length = len_type'(span);
         slot = 0;
         for (int k = 1; k <= span; k++) begin
            if ((k & (k - 1)) != 0) begin
               if (slot < MSG_BITS) begin
                  res.codeword[k-1] = msg[slot];
               end
               slot++;
            end
         end
         // Parity positions hold zero until set, so each sum sees data only.
         for (int i = 0; i < r; i++) begin
            acc = 1'b0;
            for (int k = 1; k <= span; k++) begin
               if (((k >> i) & 1) == 1) begin
                  acc ^= res.codeword[k-1];
               end
            end
            res.codeword[(1 << i) - 1] = acc;
         end
      end else begin
         span = (rx_len > MAX_WORD_LEN) ? WORD_BITS : int'(rx_len);
         for (int i = 0; i < r; i++) begin
            acc = 1'b0;
            for (int k = 1; k <= span; k++) begin
               if (((k >> i) & 1) == 1) begin
                  acc ^= rx_word[k-1];
               end
            end
            res.syndrome[i] = acc;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      coded_result_type want;
      coded_result_type got;
      int               fails;
      fails = 0;
      if (reset) begin
         error_count   <= 0;
         pending_count <= 0;
      end else begin
         // The response side goes first: a response can never belong to a
         // request taken at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            got = coded_result_type'(rsp_tdata[RSP_FIELD_BITS-1:0]);
            if (awaited_results.size() == 0) begin
               $display("%0t: response transaction with nothing awaited, data %h",
                        $realtime, rsp_tdata);
               fails++;
            end else begin
               want = awaited_results.pop_front();
               if (got.codeword !== want.codeword) begin
                  $display("%0t: codeword expected %h actual %h",
                           $realtime, want.codeword, got.codeword);
                  fails++;
               end
               if (got.codeword_length !== want.codeword_length) begin
                  $display("%0t: codeword_length expected %0d actual %0d",
                           $realtime, want.codeword_length, got.codeword_length);
                  fails++;
               end
               if (got.parity_count !== want.parity_count) begin
                  $display("%0t: parity_count expected %0d actual %0d",
                           $realtime, want.parity_count, got.parity_count);
                  fails++;
               end
               if (got.syndrome !== want.syndrome) begin
                  $display("%0t: syndrome expected %0d actual %0d",
                           $realtime, want.syndrome, got.syndrome);
                  fails++;
               end
            end
            if (rsp_tdata[RSP_TDATA_BITS-1:RSP_FIELD_BITS] !== '0) begin
               $display("%0t: padding expected 0 actual %h",
                        $realtime, rsp_tdata[RSP_TDATA_BITS-1:RSP_FIELD_BITS]);
               fails++;
            end
         end
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(hamming_outcome(req_tuser,
                                                      req_tdata[31:0],
                                                      req_tdata[37:32],
                                                      req_tdata[75:38],
                                                      req_tdata[81:76]));
         end
         error_count   <= error_count + fails;
         pending_count <= awaited_results.size();
      end
   end

endmodule

FILE: sim/hamming_encode_and_syndrome_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hamming encode and syndrome unit testbench
// Drives directed corner cases and then random encode and check transactions
// with random gaps and receiver stalls; the checker beside the unit predicts
// every response and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module hamming_encode_and_syndrome_unit_test;
   import heu_pkg::*;

   localparam int RANDOM_ITEMS = 2000;
   localparam int CALM_TAIL    = 300;

   typedef struct {
      word_type word;
      len_type  length;
      pc_type   parities;
   } codeword_entry_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;
   logic                      req_tuser  = ACT_ENCODE;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   int                        error_count;
   int                        pending_count;

   // Percentages for sender gaps and receiver stalls, changed by phase.
   int                        gap_pct   = 0;
   int                        stall_pct = 0;
   int                        stall_left = 0;

   // Recent encode responses, reused as well-formed words for checking.
   codeword_entry_type        codeword_pool[$];

   hamming_encode_and_syndrome_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   hamming_result_checker scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("hamming_encode_and_syndrome_unit_test: errors");
      $finish;
   end

   // Receiver: stalls come in bursts of random length.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(1, 13) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Keep encode results so that check transactions can carry real codewords.
   always @(posedge clock) begin
      codeword_entry_type entry;
      if (!reset && rsp_tvalid && rsp_tready && rsp_tdata[43:38] != 0) begin
         entry.word     = rsp_tdata[37:0];
         entry.length   = rsp_tdata[43:38];
         entry.parities = rsp_tdata[46:44];
         codeword_pool.push_back(entry);
         if (codeword_pool.size() > 32) begin
            void'(codeword_pool.pop_front());
         end
      end
   end

   // One request transaction, optionally after a gap; returns once accepted.
   task automatic send_request(logic act, msg_type msg, len_type msg_len,
                               word_type rx_word, len_type rx_len);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {{(REQ_TDATA_BITS - REQ_FIELD_BITS){1'b0}},
                     rx_len, rx_word, msg_len, msg};
      do @(posedge clock); while (!req_tready);
   endtask

   // A check transaction built from a stored codeword, with 0, 1 or 2 flips.
   task automatic send_received_codeword();
      codeword_entry_type entry;
      word_type           word;
      int                 flips;
      entry = codeword_pool[$urandom_range(0, codeword_pool.size() - 1)];
      word  = entry.word;
      flips = $urandom_range(0, 5);
      flips = (flips == 0) ? 0 : (flips == 5) ? 2 : 1;
      repeat (flips) begin
         word[$urandom_range(0, entry.length - 1)] ^= 1'b1;
      end
      send_request(ACT_CHECK, msg_type'($urandom),
                   len_type'(entry.length - entry.parities), word, entry.length);
   endtask

   initial begin
      logic     act;
      len_type  msg_len;
      len_type  rx_len;
      word_type rx_word;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: length extremes, parity-count boundaries, saturation,
      // zero lengths and a syndrome that points past the received length.
      send_request(ACT_ENCODE, '0, 6'd1, '0, 6'd0);
      send_request(ACT_ENCODE, '1, 6'd1, '1, 6'd63);
      send_request(ACT_ENCODE, '1, 6'd0, '0, 6'd0);
      send_request(ACT_ENCODE, '1, 6'd4, '0, 6'd0);
      send_request(ACT_ENCODE, '1, 6'd5, '0, 6'd0);
      send_request(ACT_ENCODE, '1, 6'd11, '0, 6'd0);
      send_request(ACT_ENCODE, '1, 6'd26, '0, 6'd0);
      send_request(ACT_ENCODE, '1, 6'd27, '0, 6'd0);
      send_request(ACT_ENCODE, '1, 6'd32, '0, 6'd0);
      send_request(ACT_ENCODE, 32'hA5C3_0F96, 6'd32, '1, 6'd38);
      send_request(ACT_ENCODE, '1, 6'd33, '0, 6'd0);
      send_request(ACT_ENCODE, 32'h5A3C_F069, 6'd63, '0, 6'd0);
      send_request(ACT_CHECK, '0, 6'd32, '0, 6'd38);
      send_request(ACT_CHECK, '1, 6'd32, '1, 6'd38);
      send_request(ACT_CHECK, '0, 6'd32, '1, 6'd0);
      send_request(ACT_CHECK, '0, 6'd63, '1, 6'd63);
      send_request(ACT_CHECK, '0, 6'd0, '1, 6'd38);
      send_request(ACT_CHECK, '0, 6'd32, word_type'(38'b1100), 6'd4);
      send_request(ACT_CHECK, '0, 6'd1, word_type'(38'b10000), 6'd5);
      send_request(ACT_CHECK, '0, 6'd32, word_type'(1) << 36, 6'd37);
      send_request(ACT_CHECK, '0, 6'd32, word_type'(1) << 37, 6'd38);
      send_request(ACT_CHECK, '1, 6'd26, '1, 6'd31);

      // Random part: phases of 200 transactions with their own gap and stall
      // rates, and no idling at all in the closing stretch.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 200 == 0) begin
            case ($urandom_range(0, 3))
               0: begin
                  gap_pct   = 0;
                  stall_pct = 0;
               end
               1: begin
                  gap_pct   = 10;
                  stall_pct = 10;
               end
               2: begin
                  gap_pct   = 40;
                  stall_pct = 5;
               end
               default: begin
                  gap_pct   = 5;
                  stall_pct = 40;
               end
            endcase
         end
         if (n >= RANDOM_ITEMS - CALM_TAIL) begin
            gap_pct   = 0;
            stall_pct = 0;
         end
         act = $urandom_range(0, 1) ? ACT_CHECK : ACT_ENCODE;
         if (act == ACT_CHECK && codeword_pool.size() != 0 && $urandom_range(0, 9) < 6) begin
            send_received_codeword();
         end else begin
            msg_len = ($urandom_range(0, 4) == 0) ? len_type'($urandom_range(0, 63))
                                                  : len_type'($urandom_range(1, 32));
            rx_len  = ($urandom_range(0, 4) == 0) ? len_type'($urandom_range(0, 63))
                                                  : len_type'($urandom_range(1, 38));
            rx_word = word_type'({$urandom, $urandom});
            send_request(act, msg_type'($urandom), msg_len, rx_word, rx_len);
         end
      end
      req_tvalid <= 1'b0;

      // Drain: the checker's count is registered, so look after an edge.
      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("hamming_encode_and_syndrome_unit_test: clean");
      end else begin
         $display("hamming_encode_and_syndrome_unit_test: errors");
      end
      $finish;
   end

endmodule
